/* design/sbbd_pkg.sv */
// Shared types and constants of the spectral band beat detector.
// Used by sbbd_ctrl, sbbd_datapath and spectral_band_beat_detector; no dependencies.

package sbbd_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_BINS_DEF      = 1024;
    localparam int HISTORY_DEPTH_DEF = 5;
    localparam int BIN_BITS_DEF      = 16;

    // Fixed field and register widths.
    localparam int SUM_W    = 26;
    localparam int AMP_W    = 16;
    localparam int LEVEL_W  = 18;
    localparam int TIME_W   = 32;
    localparam int CENTER_W = 10;
    localparam int RADIUS_W = 10;
    localparam int FRAME_W  = 11;
    localparam int DIV_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd4;

    // Register reset values.
    localparam logic [CENTER_W-1:0] CENTER_RST   = 10'd0;
    localparam logic [RADIUS_W-1:0] RADIUS_RST   = 10'd5;
    localparam logic [FRAME_W-1:0]  FRAME_RST    = 11'd1024;
    localparam logic [LEVEL_W-1:0]  TRIGGER_RST  = 18'd32768;
    localparam logic [TIME_W-1:0]   COOLDOWN_RST = 32'd200000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic bin_take;   // a bin transfer completes this cycle
        logic frame_end;  // that bin closes the frame
        logic div_step;   // one quotient bit of the band mean
        logic hist_push;  // push the amplitude into the history
        logic load_out;   // decide the beat and load the output register
    } sbbd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;   // the current divide step produces the last bit
        logic out_free;   // output register can take a new result
    } sbbd_stat_t;

endpackage

/* design/spectral_band_beat_detector.sv */
// Top level of the spectral band beat detector.
// Instantiates sbbd_ctrl and sbbd_datapath; depends on sbbd_pkg.

// The block takes one spectrum magnitude bin per transfer on the slave stream and
// sums the bins whose index falls inside the configured band window. Within a
// frame a bin is taken every cycle. The transfer that carries tlast closes the
// frame: the band sum is divided by the window width in a restoring divider that
// yields one quotient bit per cycle, so s_tready stays low through the divide
// steps, the history push and the beat decision, and longer while a previous
// result still waits in the output register. Each frame gives one result
// transfer with the band amplitude, the sum of the newest amplitudes, the beat
// flag and the empty window flag. Registers are written through the cfg
// channel, which is always ready; indexes beyond the register list are
// ignored. There is no clearing pass after reset.

module spectral_band_beat_detector #(
    parameter int MAX_BINS      = sbbd_pkg::MAX_BINS_DEF,
    parameter int HISTORY_DEPTH = sbbd_pkg::HISTORY_DEPTH_DEF,
    parameter int BIN_BITS      = sbbd_pkg::BIN_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Bin stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: bin_value, time_now, zero padding.
    input  logic [((BIN_BITS + sbbd_pkg::TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                s_tlast,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: band_amplitude, recent_level, zero padding.
    output logic [((sbbd_pkg::AMP_W + sbbd_pkg::LEVEL_W + 7) / 8) * 8 - 1:0] m_tdata,
    // m_tuser from bit 0: beat, empty_band.
    output logic [1:0]                          m_tuser
);
    import sbbd_pkg::*;

    localparam int OUTW = ((AMP_W + LEVEL_W + 7) / 8) * 8;

    sbbd_cmd_t  cmd;
    sbbd_stat_t stat;

    logic [AMP_W-1:0]   band_amplitude;
    logic [LEVEL_W-1:0] recent_level;
    logic               beat;
    logic               empty_band;

    // The controller paces the frame and the datapath does the arithmetic.
    sbbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbbd_datapath #(
        .MAX_BINS      (MAX_BINS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .BIN_BITS      (BIN_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .bin_value      (s_tdata[BIN_BITS-1:0]),
        .time_now       (s_tdata[BIN_BITS +: TIME_W]),
        .cmd            (cmd),
        .stat           (stat),
        .m_tready       (m_tready),
        .out_valid      (m_tvalid),
        .band_amplitude (band_amplitude),
        .recent_level   (recent_level),
        .beat           (beat),
        .empty_band     (empty_band)
    );

    // Results are packed with the amplitude in the lowest bits.
    assign m_tdata = OUTW'({recent_level, band_amplitude});
    assign m_tuser = {empty_band, beat};

    // The bin stream stalls in the cycle right after a frame-closing transfer.
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("bin stream not stalled after frame end");

    // A new result appears only after a decision cycle with the stream stalled.
    a_result_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a closed frame");

    // An empty window always reports a zero amplitude.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[AMP_W-1:0] == '0)
        else $error("empty window with nonzero amplitude");

    // A beat needs a level above the trigger, which is never below zero.
    a_beat_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[AMP_W +: LEVEL_W] != '0)
        else $error("beat with zero recent level");

endmodule

/* design/sbbd_ctrl.sv */
// Frame sequencer of the spectral band beat detector.
// Depends on sbbd_pkg for the command and status structs.

module sbbd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    input  sbbd_pkg::sbbd_stat_t stat,
    output sbbd_pkg::sbbd_cmd_t  cmd
);
    import sbbd_pkg::*;

    typedef enum logic [1:0] {ST_RUN, ST_DIV, ST_PUSH, ST_EMIT} state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.bin_take = 1'b1;
                    if (s_tlast)
                    begin
                        cmd.frame_end = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.hist_push = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
        ready_next = (state_next == ST_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

/* design/sbbd_datapath.sv */
// Datapath of the spectral band beat detector: registers, band sum, divider,
// history and beat decision. Depends on sbbd_pkg.

module sbbd_datapath #(
    parameter int MAX_BINS      = sbbd_pkg::MAX_BINS_DEF,
    parameter int HISTORY_DEPTH = sbbd_pkg::HISTORY_DEPTH_DEF,
    parameter int BIN_BITS      = sbbd_pkg::BIN_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [BIN_BITS-1:0]                 bin_value,
    input  logic [sbbd_pkg::TIME_W-1:0]         time_now,
    input  sbbd_pkg::sbbd_cmd_t                 cmd,
    output sbbd_pkg::sbbd_stat_t                stat,
    input  logic                                m_tready,
    output logic                                out_valid,
    output logic [sbbd_pkg::AMP_W-1:0]          band_amplitude,
    output logic [sbbd_pkg::LEVEL_W-1:0]        recent_level,
    output logic                                beat,
    output logic                                empty_band
);
    import sbbd_pkg::*;

    localparam int CW    = $clog2(2 * MAX_BINS);
    localparam int CMPW  = ((CW > FRAME_W) ? CW : FRAME_W) + 2;
    localparam int ADDW  = ((BIN_BITS > SUM_W) ? BIN_BITS : SUM_W) + 1;
    localparam int DCW   = $clog2(SUM_W);
    localparam int HN    = HISTORY_DEPTH - 1;
    localparam int LVW   = AMP_W + $clog2(HISTORY_DEPTH);
    localparam int LXW   = (LVW > LEVEL_W) ? LVW : LEVEL_W;

    // Configuration registers.
    logic [CENTER_W-1:0] center_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [LEVEL_W-1:0]  trigger_reg;
    logic [TIME_W-1:0]   cooldown_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg   <= CENTER_RST;
            radius_reg   <= RADIUS_RST;
            frame_reg    <= FRAME_RST;
            trigger_reg  <= TRIGGER_RST;
            cooldown_reg <= COOLDOWN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER:   center_reg   <= cfg_data[CENTER_W-1:0];
                REG_RADIUS:   radius_reg   <= cfg_data[RADIUS_W-1:0];
                REG_FRAME:    frame_reg    <= cfg_data[FRAME_W-1:0];
                REG_TRIGGER:  trigger_reg  <= cfg_data[LEVEL_W-1:0];
                REG_COOLDOWN: cooldown_reg <= cfg_data[TIME_W-1:0];
                default:      ;
            endcase
        end
    end

    // Window bounds [lo, hi), compared as signed values.
    logic signed [CMPW-1:0] lo_s, hi_s, top_s, up_s, cnt_s, width_s;
    logic                   in_win, win_empty;
    logic [CW-1:0]          cnt_reg;
    logic [SUM_W-1:0]       sum_reg, sum_new;
    logic [ADDW-1:0]        sum_add;

    always_comb
    begin
        lo_s  = (center_reg >= radius_reg) ? CMPW'(center_reg - radius_reg) : '0;
        up_s  = CMPW'(center_reg) + CMPW'(radius_reg);
        top_s = CMPW'(frame_reg) - CMPW'(1);
        hi_s  = (up_s < top_s) ? up_s : top_s;
        cnt_s = CMPW'(cnt_reg);
        in_win    = (cnt_s >= lo_s) && (cnt_s < hi_s);
        win_empty = (hi_s <= lo_s);
        width_s   = hi_s - lo_s;
        sum_add   = ADDW'(sum_reg) + ADDW'(bin_value);
        if (!in_win)
            sum_new = sum_reg;
        else if (sum_add > ADDW'(SUM_MAX))
            sum_new = SUM_MAX;
        else
            sum_new = sum_add[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.bin_take)
        begin
            if (cmd.frame_end)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_new;
                if (cnt_reg != '1)
                    cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    logic [DIV_W-1:0] rem_reg, divisor_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic             empty_reg;
    logic [TIME_W-1:0] time_reg;
    logic [DIV_W+1:0] trial;
    logic [DIV_W:0]   shifted;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.frame_end)
        begin
            rem_reg     <= '0;
            quo_reg     <= sum_new;
            divisor_reg <= width_s[DIV_W-1:0];
            empty_reg   <= win_empty;
            time_reg    <= time_now;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial[DIV_W+1] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], ~trial[DIV_W+1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.frame_end)
            dcnt_reg <= '0;
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg + DCW'(1);
    end

    assign stat.div_last = (dcnt_reg == DCW'(SUM_W - 1));

    // History of amplitudes with a running sum of the held entries.
    logic [AMP_W-1:0] amp_val, amp_reg;
    logic [AMP_W-1:0] hist_reg [HN];
    logic [LVW-1:0]   run_reg;

    always_comb
    begin
        if (empty_reg)
            amp_val = '0;
        else if (|quo_reg[SUM_W-1:AMP_W])
            amp_val = '1;
        else
            amp_val = quo_reg[AMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HN; i++)
                hist_reg[i] <= '0;
            run_reg <= '0;
        end
        else if (cmd.hist_push)
        begin
            hist_reg[0] <= amp_val;
            for (int i = 1; i < HN; i++)
                hist_reg[i] <= hist_reg[i-1];
            run_reg <= run_reg + LVW'(amp_val) - LVW'(hist_reg[HN-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_push)
            amp_reg <= amp_val;
    end

    // Beat decision and output register.
    logic [LXW-1:0]     level_ext;
    logic [LEVEL_W-1:0] level_sat;
    logic [TIME_W:0]    deadline;
    logic               beat_now;
    logic               out_valid_reg;
    logic [TIME_W-1:0]  last_beat_reg;

    always_comb
    begin
        level_ext = LXW'(run_reg);
        level_sat = (level_ext > LXW'(LEVEL_MAX)) ? LEVEL_MAX : level_ext[LEVEL_W-1:0];
        deadline  = {1'b0, last_beat_reg} + {1'b0, cooldown_reg};
        beat_now  = (level_sat > trigger_reg) && ({1'b0, time_reg} > deadline);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_beat_reg <= '0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.load_out && beat_now)
                last_beat_reg <= time_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            band_amplitude <= amp_reg;
            recent_level   <= level_sat;
            beat           <= beat_now;
            empty_band     <= empty_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign out_valid     = out_valid_reg;

endmodule
